/* sv/carc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// carc_pkg
// Shared types, constants and helpers of the comb/allpass reverb channel.
// ----------------------------------------------------------------------------
package carc_pkg;

	localparam int SampleWidth = 24;
	localparam int CombBankDepth = 2048;
	localparam int ApBankDepth = 1024;
	localparam int CombAw = 13;
	localparam int ApAw = 12;
	localparam int CombPw = 11;
	localparam int ApPw = 10;

	// left side comb lengths, allpass lengths, tap constants
	localparam logic [CombPw-1:0] CombLen [4] = '{11'd1557, 11'd1617, 11'd1491, 11'd1422};
	localparam logic [ApPw-1:0] ApLen [4] = '{10'd556, 10'd441, 10'd341, 10'd225};
	localparam logic [8:0] TapRoom [2] = '{9'd400, 9'd350};
	localparam logic [5:0] TapChaos [2] = '{6'd50, 6'd40};
	localparam logic [13:0] TapGain [2] = '{14'd9830, 14'd7864};

	localparam logic [16:0] FbMax = 17'd65208;
	localparam logic [12:0] HpMin = 13'd66;
	localparam logic [12:0] HpMax = 13'd6554;
	localparam logic [12:0] CtlMax = 13'd4096;

	typedef logic signed [SampleWidth-1:0] sample_t;

	// multiplier operation codes
	typedef enum logic [1:0] {
		MUL_Q16 = 2'd0,
		MUL_Q12 = 2'd1,
		MUL_RAW = 2'd2
	} mul_op_t;

	// saturate a wide signed value to the sample width
	function automatic sample_t sat(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd8388607;
		lo = -64'sd8388608;
		if (v > hi)
			sat = sample_t'(hi);
		else if (v < lo)
			sat = sample_t'(lo);
		else
			sat = sample_t'(v);
	endfunction

	// round half up then shift right arithmetic
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
			input logic [5:0] s);
		logic signed [63:0] h;
		h = (s == 6'd0) ? 64'sd0 : (64'sd1 <<< (s - 6'd1));
		rnd = (v + h) >>> s;
	endfunction

endpackage
`default_nettype wire

/* sv/carc_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// carc_stream_if
// Valid/ready channels of the reverb channel: input, output and config.
// ----------------------------------------------------------------------------
interface carc_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] dry_sample;
	logic [12:0] room_size;
	logic [12:0] damping;
	logic [12:0] decay;
	logic chaos_enable;
	logic signed [13:0] chaos_value;
	modport source (output valid, dry_sample, room_size, damping, decay,
		chaos_enable, chaos_value, input ready);
	modport sink (input valid, dry_sample, room_size, damping, decay,
		chaos_enable, chaos_value, output ready);
endinterface

interface carc_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] wet_sample;
	modport source (output valid, wet_sample, input ready);
	modport sink (input valid, wet_sample, output ready);
endinterface

interface carc_cfg_if;
	logic valid;
	logic ready;
	logic [12:0] hp_coefficient;
	modport source (output valid, hp_coefficient, input ready);
	modport sink (input valid, hp_coefficient, output ready);
endinterface
`default_nettype wire

/* sv/carc_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// carc_mul
// Shared registered multiplier with rounding shift, used by the multiply steps.
// ----------------------------------------------------------------------------
module carc_mul (
	input  wire logic                clk,
	input  wire logic signed [31:0]  a,
	input  wire logic signed [31:0]  b,
	input  wire logic [5:0]          shift,
	output logic signed [63:0]       y_q
);
	logic signed [63:0] prod_s1;
	logic [5:0] shift_s1;

	// multiply, then round in the following cycle
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(a) * 64'(b);
		shift_s1 <= shift;
		y_q <= carc_pkg::rnd(prod_s1, shift_s1);
	end
endmodule
`default_nettype wire

/* sv/comb_allpass_reverb_channel_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// comb_allpass_reverb_channel_unit
// Mono comb/allpass reverb channel with highpass output.
// ----------------------------------------------------------------------------
// Each accepted sample runs through the coefficient steps, the comb steps, the
// room tap steps, a sum step, the allpass steps, the highpass steps and the
// output load, and the input is ready again in the cycle after that load. A
// sequencer walks the four combs, the two room taps, the four allpasses and the
// highpass, one memory access or one multiply on the shared two-stage multiplier
// per step. After reset a clearing pass zeroes the comb and allpass memories
// before the first request is taken. The result register frees the input once
// it is loaded; a result that is still waiting there holds the next one in the
// output step.
module comb_allpass_reverb_channel_unit (
	input wire logic clk,
	input wire logic arst_n,
	carc_in_if.sink  in_ch,
	carc_out_if.source out_ch,
	carc_cfg_if.sink cfg_ch
);
	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_COEF  = 9'b000000100,
		ST_COMB  = 9'b000001000,
		ST_TAP   = 9'b000010000,
		ST_SUM   = 9'b000100000,
		ST_AP    = 9'b001000000,
		ST_HP    = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [3:0] step_q;
	logic [1:0] idx_q;
	logic [12:0] clr_q;
	logic out_valid_q;
	carc_pkg::sample_t out_q;
	logic [12:0] hp_coef_q;

	// memories
	carc_pkg::sample_t comb_mem [4*carc_pkg::CombBankDepth];
	carc_pkg::sample_t ap_mem [4*carc_pkg::ApBankDepth];
	carc_pkg::sample_t comb_rd_q, ap_rd_q;
	logic [carc_pkg::CombAw-1:0] comb_ra, comb_wa;
	logic [carc_pkg::ApAw-1:0] ap_ra, ap_wa;
	logic comb_we, ap_we;
	carc_pkg::sample_t comb_wd, ap_wd;

	logic [carc_pkg::CombPw-1:0] cpos_q [4];
	carc_pkg::sample_t lp_q [4];
	logic [carc_pkg::ApPw-1:0] apos_q [4];
	carc_pkg::sample_t hp_q;

	// latched request values
	carc_pkg::sample_t dry_q;
	logic [12:0] room_q, damp_q, decay_q;
	logic en_q;
	logic signed [13:0] chaos_q;
	logic signed [17:0] fb_q;
	logic [16:0] dc_q;
	logic [17:0] rs_q;
	logic [carc_pkg::CombPw-1:0] tap_q [2];
	carc_pkg::sample_t room_in_q, x_q, o_q, lp_new_q;
	logic signed [29:0] acc_q;
	logic signed [37:0] tmp_q;

	// multiplier
	logic signed [31:0] ma, mb;
	logic [5:0] msh;
	logic signed [63:0] my;
	carc_mul u_mul (.clk(clk), .a(ma), .b(mb), .shift(msh), .y_q(my));

	// saturated controls of the held request
	function automatic logic [12:0] ctl(input logic [12:0] v);
		ctl = (v > carc_pkg::CtlMax) ? carc_pkg::CtlMax : v;
	endfunction

	logic signed [13:0] chaos_c;
	assign chaos_c = (chaos_q > 14'sd4096) ? 14'sd4096 :
		((chaos_q < -14'sd4096) ? -14'sd4096 : chaos_q);

	// tap offsets: combinational, narrow
	logic signed [23:0] tsum [2];
	logic [carc_pkg::CombPw-1:0] toff [2];
	logic [11:0] tidx_raw [2];
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			tsum[k] = $signed({11'd0, ctl(room_q)}) * $signed({15'd0, carc_pkg::TapRoom[k]})
				+ 24'(chaos_c) * $signed({18'd0, carc_pkg::TapChaos[k]});
			toff[k] = (tsum[k] > 24'sd0) ? carc_pkg::CombPw'(tsum[k] >>> 12)
				: '0;
			tidx_raw[k] = {1'b0, cpos_q[k]} + {1'b0, carc_pkg::CombLen[k]} - {1'b0, toff[k]};
			if (tidx_raw[k] >= {1'b0, carc_pkg::CombLen[k]})
				tidx_raw[k] = tidx_raw[k] - {1'b0, carc_pkg::CombLen[k]};
		end
	end

	logic [12:0] hp_c;
	assign hp_c = (hp_coef_q < carc_pkg::HpMin) ? carc_pkg::HpMin :
		((hp_coef_q > carc_pkg::HpMax) ? carc_pkg::HpMax : hp_coef_q);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.wet_sample = out_q;

	// memory ports
	always_ff @(posedge clk) begin
		if (comb_we)
			comb_mem[comb_wa] <= comb_wd;
		comb_rd_q <= comb_mem[comb_ra];
		if (ap_we)
			ap_mem[ap_wa] <= ap_wd;
		ap_rd_q <= ap_mem[ap_ra];
	end

	// per-step datapath and memory control
	always_comb begin
		ma = '0;
		mb = '0;
		msh = 6'd0;
		comb_ra = {idx_q, cpos_q[idx_q]};
		comb_wa = {idx_q, cpos_q[idx_q]};
		comb_we = 1'b0;
		comb_wd = '0;
		ap_ra = {idx_q, apos_q[idx_q]};
		ap_wa = {idx_q, apos_q[idx_q]};
		ap_we = 1'b0;
		ap_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				comb_we = 1'b1;
				comb_wa = clr_q;
				ap_we = !clr_q[12];
				ap_wa = clr_q[11:0];
			end
			ST_COEF: begin
				case (step_q)
					4'd0: begin ma = 32'(ctl(decay_q)); mb = 32'sd31785; msh = 6'd12; end
					4'd1: begin ma = 32'(ctl(damp_q)); mb = 32'sd58982; msh = 6'd12; end
					4'd2: begin ma = 32'(ctl(room_q)); mb = 32'sd91750; msh = 6'd12; end
					4'd5: begin ma = 32'(dry_q); mb = 32'(rs_q); msh = 6'd16; end
					default: ;
				endcase
			end
			ST_COMB: begin
				case (step_q)
					4'd2: begin ma = 32'(o_q) - 32'(lp_q[idx_q]); mb = 32'(dc_q); msh = 6'd16; end
					4'd5: begin ma = 32'(lp_new_q); mb = 32'(fb_q); msh = 6'd16; end
					4'd7: begin
						comb_we = 1'b1;
						comb_wd = carc_pkg::sat(64'(room_in_q) + my);
					end
					default: ;
				endcase
			end
			ST_TAP: begin
				comb_ra = {idx_q, tap_q[idx_q[0]]};
				case (step_q)
					4'd2: begin
						ma = 32'(ctl(room_q));
						mb = 32'(carc_pkg::TapGain[idx_q[0]]);
						msh = 6'd0;
					end
					4'd5: begin ma = 32'(comb_rd_q); mb = 32'(tmp_q); msh = 6'd28; end
					default: ;
				endcase
			end
			ST_AP: begin
				if (step_q == 4'd2) begin
					ap_we = 1'b1;
					ap_wd = carc_pkg::sat(64'(x_q) + carc_pkg::rnd(64'(ap_rd_q), 6'd1));
				end
			end
			ST_HP: begin
				if (step_q == 4'd0) begin
					ma = 32'(x_q) - 32'(hp_q); mb = 32'(hp_c); msh = 6'd16;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q <= '0;
			idx_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			hp_coef_q <= 13'd297;
			for (int k = 0; k < 4; k++) begin
				cpos_q[k] <= '0;
				lp_q[k] <= '0;
				apos_q[k] <= '0;
			end
			hp_q <= '0;
		end else begin
			if (cfg_ch.valid)
				hp_coef_q <= cfg_ch.hp_coefficient;
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 13'd1;
					if (clr_q == 13'd8191)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						dry_q <= in_ch.dry_sample;
						room_q <= in_ch.room_size;
						damp_q <= in_ch.damping;
						decay_q <= in_ch.decay;
						en_q <= in_ch.chaos_enable;
						chaos_q <= in_ch.chaos_value;
						step_q <= '0;
						state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd0: begin
							// tap positions from the pointers before the combs write
							tap_q[0] <= tidx_raw[0][carc_pkg::CombPw-1:0];
							tap_q[1] <= tidx_raw[1][carc_pkg::CombPw-1:0];
						end
						4'd2: fb_q <= 18'sd32768 + 18'(my);
						4'd3: begin
							dc_q <= 17'(17'd3277 + 17'(my));
							if (en_q) begin
								if (fb_q + 18'(chaos_c) * 18'sd8 < 18'sd0)
									fb_q <= '0;
								else if (fb_q + 18'(chaos_c) * 18'sd8 > 18'(carc_pkg::FbMax))
									fb_q <= 18'(carc_pkg::FbMax);
								else
									fb_q <= fb_q + 18'(chaos_c) * 18'sd8;
							end
						end
						4'd4: rs_q <= 18'(18'd19661 + 18'(my));
						4'd7: begin
							room_in_q <= carc_pkg::sat(my);
							acc_q <= '0;
							idx_q <= '0;
							step_q <= '0;
							state_q <= ST_COMB;
						end
						default: ;
					endcase
				end
				ST_COMB: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd1: o_q <= comb_rd_q;
						4'd4: lp_new_q <= carc_pkg::sat(64'(lp_q[idx_q]) + my);
						4'd5: lp_q[idx_q] <= lp_new_q;
						4'd8: begin
							acc_q <= acc_q + 30'(o_q);
							cpos_q[idx_q] <= (cpos_q[idx_q] + 11'd1 >= carc_pkg::CombLen[idx_q])
								? '0 : cpos_q[idx_q] + 11'd1;
							step_q <= '0;
							idx_q <= idx_q + 2'd1;
							if (idx_q == 2'd3) begin
								state_q <= ST_TAP;
								idx_q <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_TAP: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd4: tmp_q <= 38'(my);
						4'd7: begin
							acc_q <= acc_q + 30'(my);
							step_q <= '0;
							idx_q <= idx_q + 2'd1;
							if (idx_q == 2'd1) begin
								state_q <= ST_SUM;
								idx_q <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_SUM: begin
					x_q <= carc_pkg::sat(carc_pkg::rnd(64'(acc_q), 6'd2));
					step_q <= '0;
					state_q <= ST_AP;
				end
				ST_AP: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd2) begin
						x_q <= carc_pkg::sat(64'(ap_rd_q) - carc_pkg::rnd(64'(x_q), 6'd1));
						apos_q[idx_q] <= (apos_q[idx_q] + 10'd1 >= carc_pkg::ApLen[idx_q])
							? '0 : apos_q[idx_q] + 10'd1;
						step_q <= '0;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_q <= ST_HP;
							idx_q <= '0;
						end
					end
				end
				ST_HP: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd2)
						hp_q <= carc_pkg::sat(64'(hp_q) + my);
					if (step_q == 4'd3) begin
						x_q <= carc_pkg::sat(64'(x_q) - 64'(hp_q));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// load the result register once it is free
					if (!out_valid_q || out_ch.ready) begin
						out_q <= x_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && (!out_valid_q || out_ch.ready)) |=> out_valid_q)
		else $error("result not presented");
endmodule
`default_nettype wire

/* tb/sv/comb_allpass_reverb_channel_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// comb_allpass_reverb_channel_unit_tb
// Drives dry samples with random controls and handshake gaps through the
// reverb channel, predicts every wet sample with a bit-true model of the
// comb, tap, allpass and highpass chain, and compares results in order.
// ----------------------------------------------------------------------------
module comb_allpass_reverb_channel_unit_tb;

	localparam int WatchdogLimit = 40000;
	localparam int DirectedRows = 18;

	// one row of directed stimulus; has_wet marks a typed-in expectation
	typedef struct {
		logic signed [23:0] dry;
		logic [12:0] room;
		logic [12:0] damp;
		logic [12:0] decay;
		logic chaos_on;
		logic signed [13:0] chaos;
		logic has_wet;
		logic signed [23:0] wet;
	} sample_row_t;

	typedef struct {
		logic signed [23:0] dry;
		logic [12:0] room;
		logic [12:0] damp;
		logic [12:0] decay;
		logic chaos_on;
		logic signed [13:0] chaos;
	} sample_req_t;

	logic clk;
	logic arst_n;

	carc_in_if in_ch();
	carc_out_if out_ch();
	carc_cfg_if cfg_ch();

	comb_allpass_reverb_channel_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// predictor state
	longint comb_mem [4][carc_pkg::CombBankDepth];
	int comb_pos [4];
	longint comb_lp [4];
	longint ap_mem [4][carc_pkg::ApBankDepth];
	int ap_pos [4];
	longint hp_mem;
	longint hp_coef;

	logic signed [23:0] wet_expected [$];
	sample_row_t directed_rows [DirectedRows];
	int mismatches;
	int idle_cycles;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint clip(longint v);
		return v > 8388607 ? 64'sd8388607 : (v < -8388608 ? -64'sd8388608 : v);
	endfunction

	function automatic longint round_shift(longint v, int s);
		longint h;
		h = s == 0 ? 0 : (64'sd1 <<< (s - 1));
		return (v + h) >>> s;
	endfunction

	function automatic longint control_level(logic [12:0] v);
		return v > 13'd4096 ? 64'sd4096 : longint'(v);
	endfunction

	function automatic void clear_reverb_state();
		for (int k = 0; k < 4; k++) begin
			comb_pos[k] = 0;
			comb_lp[k] = 0;
			ap_pos[k] = 0;
			for (int i = 0; i < carc_pkg::CombBankDepth; i++)
				comb_mem[k][i] = 0;
			for (int i = 0; i < carc_pkg::ApBankDepth; i++)
				ap_mem[k][i] = 0;
		end
		hp_mem = 0;
		hp_coef = 297;
	endfunction

	// bit-true wet sample for one dry request
	function automatic logic signed [23:0] reverb_wet(sample_req_t r);
		longint dry, room, damp, decay, chaos, fb, dc, rs, room_in, acc, x, coef;
		longint len, s, off, o, lp, d, y, v;
		longint tap_at [2];
		dry = longint'(r.dry);
		room = control_level(r.room);
		damp = control_level(r.damp);
		decay = control_level(r.decay);
		chaos = longint'(r.chaos);
		if (chaos > 4096) chaos = 4096;
		if (chaos < -4096) chaos = -4096;
		fb = 32768 + round_shift(decay * 31785, 12);
		if (r.chaos_on) begin
			fb += chaos * 8;
			if (fb < 0) fb = 0;
			if (fb > 65208) fb = 65208;
		end
		dc = 3277 + round_shift(damp * 58982, 12);
		rs = 19661 + round_shift(room * 91750, 12);
		// tap positions from the pre-write pointers
		for (int k = 0; k < 2; k++) begin
			len = longint'(carc_pkg::CombLen[k]);
			s = room * longint'(carc_pkg::TapRoom[k]) + chaos * longint'(carc_pkg::TapChaos[k]);
			off = s > 0 ? (s >>> 12) : 0;
			off = off % len;
			tap_at[k] = (longint'(comb_pos[k]) + len - off) % len;
		end
		// damped combs
		room_in = clip(round_shift(dry * rs, 16));
		acc = 0;
		for (int k = 0; k < 4; k++) begin
			len = longint'(carc_pkg::CombLen[k]);
			o = comb_mem[k][comb_pos[k]];
			lp = clip(comb_lp[k] + round_shift((o - comb_lp[k]) * dc, 16));
			comb_lp[k] = lp;
			comb_mem[k][comb_pos[k]] = clip(room_in + round_shift(lp * fb, 16));
			comb_pos[k] = comb_pos[k] + 1 >= len ? 0 : comb_pos[k] + 1;
			acc += o;
		end
		for (int k = 0; k < 2; k++) begin
			v = comb_mem[k][tap_at[k]];
			acc += round_shift(v * room * longint'(carc_pkg::TapGain[k]), 28);
		end
		x = clip(round_shift(acc, 2));
		// allpass chain
		for (int k = 0; k < 4; k++) begin
			len = longint'(carc_pkg::ApLen[k]);
			d = ap_mem[k][ap_pos[k]];
			y = clip(d - round_shift(x, 1));
			ap_mem[k][ap_pos[k]] = clip(x + round_shift(d, 1));
			ap_pos[k] = ap_pos[k] + 1 >= len ? 0 : ap_pos[k] + 1;
			x = y;
		end
		// highpass
		coef = hp_coef;
		if (coef < 66) coef = 66;
		if (coef > 6554) coef = 6554;
		hp_mem = clip(hp_mem + round_shift((x - hp_mem) * coef, 16));
		x = clip(x - hp_mem);
		return x[23:0];
	endfunction

	function automatic sample_row_t make_row(longint dry, int room, int damp, int decay,
			bit en, int chaos, bit has_wet, longint wet);
		sample_row_t r;
		r.dry = dry[23:0];
		r.room = room[12:0];
		r.damp = damp[12:0];
		r.decay = decay[12:0];
		r.chaos_on = en;
		r.chaos = chaos[13:0];
		r.has_wet = has_wet;
		r.wet = wet[23:0];
		return r;
	endfunction

	// mostly short gaps, a few long ones, some none
	function automatic int gap_cycles();
		int p;
		p = $urandom_range(99);
		if (p < 40) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(200, 20);
	endfunction

	// valid stays high after an accept until the next request or a drain
	task automatic send_sample(sample_req_t r);
		int g;
		g = gap_cycles();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.dry_sample <= r.dry;
		in_ch.room_size <= r.room;
		in_ch.damping <= r.damp;
		in_ch.decay <= r.decay;
		in_ch.chaos_enable <= r.chaos_on;
		in_ch.chaos_value <= r.chaos;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		wet_expected.push_back(reverb_wet(r));
	endtask

	task automatic write_hp_coefficient(logic [12:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.hp_coefficient <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		hp_coef = longint'(v);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (wet_expected.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic sample_req_t random_sample();
		sample_req_t r;
		int p;
		p = $urandom_range(9);
		r.dry = 24'($urandom());
		if (p < 3) r.dry = r.dry >>> 4;
		r.room = p == 0 ? 13'($urandom()) : 13'($urandom_range(4096));
		r.damp = p == 1 ? 13'($urandom()) : 13'($urandom_range(4096));
		r.decay = p == 2 ? 13'($urandom()) : 13'($urandom_range(4096));
		r.chaos_on = 1'($urandom_range(1));
		r.chaos = p == 3 ? 14'($urandom()) : 14'($urandom_range(8192) - 4096);
		return r;
	endfunction

	// result sink with random stalls and checking
	initial begin
		int stall;
		logic signed [23:0] exp_wet;
		out_ch.ready = 1'b0;
		mismatches = 0;
		@(posedge arst_n);
		forever begin
			stall = gap_cycles();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			if (wet_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected wet sample %0d", out_ch.wet_sample);
			end else begin
				exp_wet = wet_expected.pop_front();
				if (out_ch.wet_sample !== exp_wet) begin
					mismatches++;
					if (mismatches <= 10)
						$display("wet_sample mismatch: expected %0d actual %0d",
							exp_wet, out_ch.wet_sample);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on the input, output or config channel
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("comb_allpass_reverb_channel_unit verification failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		sample_row_t row;
		sample_req_t r;
		int hp_settings [5];
		in_ch.valid = 1'b0;
		in_ch.dry_sample = '0;
		in_ch.room_size = '0;
		in_ch.damping = '0;
		in_ch.decay = '0;
		in_ch.chaos_enable = 1'b0;
		in_ch.chaos_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.hp_coefficient = '0;
		arst_n = 1'b0;
		clear_reverb_state();
		hp_settings = '{6554, 66, 13'h1FFF, 0, 1234};
		// zero input after reset gives silence; the rest go to the predictor
		directed_rows[0] = make_row(0, 0, 0, 0, 0, 0, 1, 0);
		directed_rows[1] = make_row(0, 4096, 4096, 4096, 1, 4096, 1, 0);
		directed_rows[2] = make_row(8388607, 4096, 0, 4096, 0, 0, 0, 0);
		directed_rows[3] = make_row(-8388608, 4096, 4096, 4096, 1, 4096, 0, 0);
		directed_rows[4] = make_row(8388607, 8191, 8191, 8191, 1, 8191, 0, 0);
		directed_rows[5] = make_row(-8388608, 0, 0, 0, 1, -8192, 0, 0);
		directed_rows[6] = make_row(-1, 5000, 0, 0, 1, -4096, 0, 0);
		directed_rows[7] = make_row(1, 4096, 4096, 0, 0, 8191, 0, 0);
		directed_rows[8] = make_row(4194304, 4096, 2048, 4096, 1, 4096, 0, 0);
		directed_rows[9] = make_row(-4194304, 0, 4096, 4096, 1, -4097, 0, 0);
		directed_rows[10] = make_row(8388607, 2048, 2048, 2048, 0, -8192, 0, 0);
		directed_rows[11] = make_row(0, 4096, 0, 4096, 1, 4096, 0, 0);
		directed_rows[12] = make_row(-8388608, 4096, 0, 4096, 0, 4096, 0, 0);
		directed_rows[13] = make_row(5592405, 2730, 5461, 1365, 1, 5461, 0, 0);
		directed_rows[14] = make_row(-5592406, 5461, 2730, 6826, 0, -5462, 0, 0);
		directed_rows[15] = make_row(0, 0, 0, 0, 0, 0, 0, 0);
		directed_rows[16] = make_row(0, 0, 0, 0, 1, 0, 0, 0);
		directed_rows[17] = make_row(8388607, 4096, 4096, 4096, 1, -4096, 0, 0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, with typed-in values checked against the predictor
		for (int i = 0; i < DirectedRows; i++) begin
			row = directed_rows[i];
			r.dry = row.dry;
			r.room = row.room;
			r.damp = row.damp;
			r.decay = row.decay;
			r.chaos_on = row.chaos_on;
			r.chaos = row.chaos;
			send_sample(r);
			if (row.has_wet && wet_expected[$] !== row.wet) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: expected %0d predicted %0d", i, row.wet,
						wet_expected[$]);
			end
		end
		wait_drained();

		// random part across several highpass settings
		for (int ph = 0; ph < 5; ph++) begin
			write_hp_coefficient(13'(hp_settings[ph]));
			for (int n = 0; n < 280; n++)
				send_sample(random_sample());
			wait_drained();
		end

		if (mismatches == 0)
			$display("comb_allpass_reverb_channel_unit verification clean");
		else
			$display("comb_allpass_reverb_channel_unit verification failed");
		$finish;
	end

endmodule
`default_nettype wire
